// ===== rtl/subarray_with_target_sum_core_defines.svh =====
// Assertion macros for the subarray-with-target-sum core.
`ifndef SUBARRAY_WITH_TARGET_SUM_CORE_DEFINES_SVH
`define SUBARRAY_WITH_TARGET_SUM_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swts_pkg.sv =====
// Shared constants and types for the subarray-with-target-sum core.
package swts_pkg;

    localparam int MAX_LEN_DEF   = 1024;
    localparam int ELEM_BITS_DEF = 32;
    localparam int TARGET_W      = 42;
    localparam int POS_W         = 11;
    localparam int Q_DEPTH       = 4;

    typedef struct packed {
        logic last;
        logic over;
    } t_item_ctl;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
        logic             too_long;
    } t_result;

endpackage

// ===== rtl/swts_front.sv =====
// Front end: accepts words, tags index and overflow, queues them for the window engine.
module swts_front #(
    parameter int ELEM_BITS = swts_pkg::ELEM_BITS_DEF,
    parameter int MAX_LEN   = swts_pkg::MAX_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [ELEM_BITS-1:0]       i_value,
    input  logic                       i_last,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [ELEM_BITS-1:0]       o_value,
    output logic [$clog2(MAX_LEN)-1:0] o_idx,
    output swts_pkg::t_item_ctl        o_ctl,
    input  logic                       i_ready
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int QA_W  = $clog2(swts_pkg::Q_DEPTH);

    logic [ELEM_BITS-1:0] r_q_value [swts_pkg::Q_DEPTH];
    logic [IDX_W-1:0]     r_q_idx   [swts_pkg::Q_DEPTH];
    swts_pkg::t_item_ctl  r_q_ctl   [swts_pkg::Q_DEPTH];
    logic [QA_W-1:0]      r_wr, r_rd;
    logic [QA_W:0]        r_count;
    logic [CNT_W-1:0]     r_seen, n_seen;
    logic                 push, pop, over;

    assign o_ready = (r_count != (QA_W+1)'(swts_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign over    = (r_seen == CNT_W'(MAX_LEN));

    assign o_value = r_q_value[r_rd];
    assign o_idx   = r_q_idx[r_rd];
    assign o_ctl   = r_q_ctl[r_rd];

    // position within the current array; sticks at capacity once exceeded
    always_comb begin
        n_seen = r_seen;
        if (push) begin
            if (i_last) begin
                n_seen = '0;
            end else if (!over) begin
                n_seen = r_seen + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_seen  <= '0;
        end else begin
            r_seen <= n_seen;
            if (push) begin
                r_wr <= r_wr + QA_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QA_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (QA_W+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (QA_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_value[r_wr]    <= i_value;
            r_q_idx[r_wr]      <= r_seen[IDX_W-1:0];
            r_q_ctl[r_wr].last <= i_last;
            r_q_ctl[r_wr].over <= over;
        end
    end

endmodule

// ===== rtl/swts_back.sv =====
// Window engine: element store, running sum, left-side pops, match capture, result register.
module swts_back #(
    parameter int ELEM_BITS = swts_pkg::ELEM_BITS_DEF,
    parameter int MAX_LEN   = swts_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ELEM_BITS-1:0]          i_value,
    input  logic [$clog2(MAX_LEN)-1:0]    i_idx,
    input  swts_pkg::t_item_ctl           i_ctl,
    output logic                          o_ready,
    input  logic [swts_pkg::TARGET_W-1:0] i_target,
    output logic                          o_res_valid,
    output swts_pkg::t_result             o_res,
    input  logic                          i_res_ready
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = ((ELEM_BITS > swts_pkg::TARGET_W) ? ELEM_BITS
                                                              : swts_pkg::TARGET_W) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_OUT   = 2'd2;

    logic [ELEM_BITS-1:0] mem [MAX_LEN];
    logic [ELEM_BITS-1:0] r_rdata;

    logic [1:0]       r_state, n_state;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic             r_match, n_match;
    logic [CNT_W-1:0] r_mstart, n_mstart;
    logic [CNT_W-1:0] r_mend, n_mend;
    logic             r_over, n_over;
    logic             r_last, n_last;
    logic             r_res_valid, n_res_valid;
    logic             load_res;
    logic             mem_we;
    logic [IDX_W-1:0] rd_addr;
    logic [SUM_W-1:0] target_x;
    logic             win_live;

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign target_x    = SUM_W'(i_target);
    assign win_live    = (r_head < r_seen);
    assign load_res    = (r_state == S_OUT) && (!r_res_valid || i_res_ready);

    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_head   = r_head;
        n_seen   = r_seen;
        n_match  = r_match;
        n_mstart = r_mstart;
        n_mend   = r_mend;
        n_over   = r_over;
        n_last   = r_last;
        mem_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last = i_ctl.last;
                    if (i_ctl.over) begin
                        n_over  = 1'b1;
                        n_state = i_ctl.last ? S_OUT : S_IDLE;
                    end else if (r_match) begin
                        n_state = i_ctl.last ? S_OUT : S_IDLE;
                    end else begin
                        mem_we  = 1'b1;
                        n_sum   = r_sum + SUM_W'(i_value);
                        n_seen  = CNT_W'(i_idx) + CNT_W'(1);
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // one pop per cycle; r_rdata always holds store[r_head]
                if (r_sum > target_x && win_live) begin
                    n_sum  = r_sum - SUM_W'(r_rdata);
                    n_head = r_head + CNT_W'(1);
                end else begin
                    if (win_live && r_sum == target_x) begin
                        n_match  = 1'b1;
                        n_mstart = r_head + CNT_W'(1);
                        n_mend   = r_seen;
                    end
                    n_state = r_last ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (load_res) begin
                    n_sum    = '0;
                    n_head   = '0;
                    n_seen   = '0;
                    n_match  = 1'b0;
                    n_mstart = '0;
                    n_mend   = '0;
                    n_over   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (load_res) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    assign rd_addr = n_head[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_idx] <= i_value;
        end
        // forward the word being written when the window was empty
        r_rdata <= (mem_we && i_idx == rd_addr) ? i_value : mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_head      <= '0;
            r_seen      <= '0;
            r_match     <= 1'b0;
            r_mstart    <= '0;
            r_mend      <= '0;
            r_over      <= 1'b0;
            r_last      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_head      <= n_head;
            r_seen      <= n_seen;
            r_match     <= n_match;
            r_mstart    <= n_mstart;
            r_mend      <= n_mend;
            r_over      <= n_over;
            r_last      <= n_last;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_res) begin
            o_res.found     <= r_match;
            o_res.start_pos <= r_match ? swts_pkg::POS_W'(r_mstart) : '0;
            o_res.end_pos   <= r_match ? swts_pkg::POS_W'(r_mend) : '0;
            o_res.too_long  <= r_over;
        end
    end

endmodule

// ===== rtl/subarray_with_target_sum_core.sv =====
// Top level of the subarray-with-target-sum core: target register, stream ports, checks.
//
// Input stream s_axis carries one array element per word, tlast on the final
// element of an array. Output stream m_axis gives one result word per array,
// after its tlast element: found, 1-based start and end of the first run that
// sums exactly to the target, and too_long when the array ran past MAX_LEN
// elements (extra elements ignored). i_cfg_we/i_cfg_wdata load the target;
// write it only while the core is idle.
// A 4-word queue decouples input acceptance from the window engine, so input
// keeps flowing while the engine works or while a result waits for m_axis_tready,
// until the queue fills. Per element the engine writes the store and adds to the
// sum, then compares, dropping elements from the left of the window while the sum
// exceeds the target. Elements beyond capacity or after a match skip the store
// and the compare. The last element also loads the result register: with an idle
// engine and no drops, the last word goes through the queue, the add and compare
// states and the result register before m_axis_tvalid rises. The engine takes a
// new element only when idle; each element is dropped at most once.
// Reset clears the target, the queue and all per-array state; no store sweep.
// A stalled result holds in the output register; the engine waits behind it.
`include "subarray_with_target_sum_core_defines.svh"

module subarray_with_target_sum_core #(
    parameter int ELEM_BITS = swts_pkg::ELEM_BITS_DEF,
    parameter int MAX_LEN   = swts_pkg::MAX_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fields from bit 0: value
    input  logic [((ELEM_BITS+7)/8)*8-1:0]        s_axis_tdata,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // fields from bit 0: found, start_pos[11], end_pos[11], too_long
    output logic [23:0]                           m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [swts_pkg::TARGET_W-1:0]         i_cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_LEN);

    logic [swts_pkg::TARGET_W-1:0] r_target;
    logic                          q_valid, q_ready;
    logic [ELEM_BITS-1:0]          q_value;
    logic [IDX_W-1:0]              q_idx;
    swts_pkg::t_item_ctl           q_ctl;
    swts_pkg::t_result             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    swts_front #(
        .ELEM_BITS (ELEM_BITS),
        .MAX_LEN   (MAX_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_value (s_axis_tdata[ELEM_BITS-1:0]),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .o_valid (q_valid),
        .o_value (q_value),
        .o_idx   (q_idx),
        .o_ctl   (q_ctl),
        .i_ready (q_ready)
    );

    swts_back #(
        .ELEM_BITS (ELEM_BITS),
        .MAX_LEN   (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_value     (q_value),
        .i_idx       (q_idx),
        .i_ctl       (q_ctl),
        .o_ready     (q_ready),
        .i_target    (r_target),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {res.too_long, res.end_pos, res.start_pos, res.found};

    // a miss reports zero positions
    `SWTS_ASSERT_NOW(a_miss_zero_pos, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[22:1] == '0, "miss with nonzero position")
    // a hit has a non-empty, ordered run
    `SWTS_ASSERT_NOW(a_hit_ordered, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[11:1] != '0 && m_axis_tdata[11:1] <= m_axis_tdata[22:12], "hit with bad run bounds")
    // a stalled result word stays put
    `SWTS_ASSERT_NEXT(a_res_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule
